// ===== design/satq_pkg.sv =====
// ----------------------------------------------------------------------------
// satq_pkg
// Shared types and codes for the sorted alarm timer queue.
// ----------------------------------------------------------------------------
package satq_pkg;

   // request operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // response kind codes
   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_REJECTED = 2'd1;
   localparam logic [1:0] KIND_FIRED    = 2'd2;

   // most alarms released by one tick
   localparam int MAX_FIRE = 16;
   localparam int FIRE_W   = $clog2(MAX_FIRE + 1);
   localparam logic [FIRE_W-1:0] FIRE_LIMIT = FIRE_W'(MAX_FIRE);

   typedef struct packed {
      logic        op;
      logic [15:0] delay_seconds;
      logic [15:0] alarm_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] fired_delay;
      logic [15:0] fired_tag;
      logic        last;
   } rsp_type;

   // one stored alarm
   typedef struct packed {
      logic [31:0] expiry;
      logic [15:0] delay;
      logic [15:0] tag;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_CHECK,
      S_INS_PUT,
      S_RESULT,
      S_FIRE_CHECK,
      S_FIRE_LAST
   } state_type;

endpackage

// ===== design/satq_ram.sv =====
// ----------------------------------------------------------------------------
// satq_ram
// Generic simple dual port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module satq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, always enabled
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/satq_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// satq_rsp_reg
// Output register of the response channel; frees itself in the cycle the
// held transaction is taken.
// ----------------------------------------------------------------------------
module satq_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  satq_pkg::rsp_type load_data,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output satq_pkg::rsp_type rsp_data
);

   logic              valid_ff, valid_in;
   satq_pkg::rsp_type data_ff, data_in;

   assign free = !valid_ff || !rsp_stall;

   // next value
   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // a load never overwrites a transaction that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("response register overwritten while stalled");

endmodule

// ===== design/sorted_alarm_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue
// Bounded queue of alarms kept in expiry order in one RAM, used as a ring
// with a head pointer. Inserts walk from the tail, moving later entries up;
// ticks pop due entries from the head.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  satq_pkg::req_type req_data
//   rsp      out  rsp_valid/rsp_stall  satq_pkg::rsp_type rsp_data
//
// Insert: into an empty or full queue goes straight to the result; else the
//   walk moves entries up from the tail, one RAM read and one write per step.
// Tick: an empty queue stays idle; else due head entries are popped, then the
//   last fired alarm is sent; one head entry is checked per cycle through
//   the RAM read port, unless a stalled response holds the engine.
// Reset clears state, time, head, count and firing status; the RAM is never cleared.
// A stalled response holds the engine; requests are taken only when idle.
// ----------------------------------------------------------------------------
module sorted_alarm_timer_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  satq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output satq_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW:0]   DEPTH_WRAP = (AW + 1)'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT  = CW'(QUEUE_DEPTH);
   localparam int EW = $bits(satq_pkg::entry_type);

   // ring address: head plus logical offset, modulo depth
   function automatic logic [AW-1:0] ring_addr(logic [AW-1:0] base,
                                                logic [AW-1:0] offs);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= DEPTH_WRAP) begin
         sum = sum - DEPTH_WRAP;
      end
      return sum[AW-1:0];
   endfunction

   satq_pkg::state_type state_ff, state_in;
   logic [31:0]   now_ff, now_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [satq_pkg::FIRE_W-1:0] fired_ff, fired_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [31:0]   exp_ff, exp_in;
   logic [15:0]   dly_ff, dly_in;
   logic [15:0]   tag_ff, tag_in;
   logic [1:0]    kind_ff, kind_in;
   logic [15:0]   pend_dly_ff, pend_dly_in;
   logic [15:0]   pend_tag_ff, pend_tag_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   satq_pkg::entry_type wr_data, rd_data;

   logic              rsp_load, out_free;
   satq_pkg::rsp_type rsp_load_data;

   logic        accept, is_full, ins_move, fire_due, fire_go, fire_stop;
   logic [31:0] exp_new;

   // entry store
   satq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response output register
   satq_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_data (rsp_load_data),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // decision terms
   assign req_stall = (state_ff != satq_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == DEPTH_CNT);
   assign exp_new   = now_ff + 32'(req_data.delay_seconds);
   assign ins_move  = (rd_data.expiry >= exp_ff);
   assign fire_due  = (rd_data.expiry <= now_ff) && (fired_ff < satq_pkg::FIRE_LIMIT);
   assign fire_go   = fire_due && (!pend_valid_ff || out_free);
   assign fire_stop = (count_ff == CW'(1)) ||
                      (fired_ff + 1'b1 == satq_pkg::FIRE_LIMIT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         satq_pkg::S_IDLE: begin
            if (accept) begin
               if (req_data.op == satq_pkg::OP_INSERT) begin
                  if (is_full || count_ff == '0) begin
                     state_in = satq_pkg::S_RESULT;
                  end else begin
                     state_in = satq_pkg::S_INS_CHECK;
                  end
               end else if (count_ff != '0) begin
                  state_in = satq_pkg::S_FIRE_CHECK;
               end
            end
         end
         satq_pkg::S_INS_CHECK: begin
            if (!ins_move) begin
               state_in = satq_pkg::S_RESULT;
            end else if (idx_ff == '0) begin
               state_in = satq_pkg::S_INS_PUT;
            end
         end
         satq_pkg::S_INS_PUT: begin
            state_in = satq_pkg::S_RESULT;
         end
         satq_pkg::S_RESULT: begin
            if (out_free) begin
               state_in = satq_pkg::S_IDLE;
            end
         end
         satq_pkg::S_FIRE_CHECK: begin
            if (fire_due) begin
               if (fire_go && fire_stop) begin
                  state_in = satq_pkg::S_FIRE_LAST;
               end
            end else if (pend_valid_ff) begin
               state_in = satq_pkg::S_FIRE_LAST;
            end else begin
               state_in = satq_pkg::S_IDLE;
            end
         end
         satq_pkg::S_FIRE_LAST: begin
            if (out_free) begin
               state_in = satq_pkg::S_IDLE;
            end
         end
         default: state_in = satq_pkg::S_IDLE;
      endcase
   end

   // datapath, RAM access and response load
   always_comb begin
      now_in        = now_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      fired_in      = fired_ff;
      pend_valid_in = pend_valid_ff;
      exp_in        = exp_ff;
      dly_in        = dly_ff;
      tag_in        = tag_ff;
      kind_in       = kind_ff;
      pend_dly_in   = pend_dly_ff;
      pend_tag_in   = pend_tag_ff;
      rd_addr       = head_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      wr_data       = '{expiry: exp_ff, delay: dly_ff, tag: tag_ff};
      rsp_load      = 1'b0;
      rsp_load_data = '0;
      unique case (state_ff)
         satq_pkg::S_IDLE: begin
            if (accept) begin
               if (req_data.op == satq_pkg::OP_INSERT) begin
                  exp_in = exp_new;
                  dly_in = req_data.delay_seconds;
                  tag_in = req_data.alarm_tag;
                  if (is_full) begin
                     kind_in = satq_pkg::KIND_REJECTED;
                  end else begin
                     kind_in = satq_pkg::KIND_ACCEPTED;
                     if (count_ff == '0) begin
                        // empty queue: store at the head at once
                        wr_en    = 1'b1;
                        wr_data  = '{expiry: exp_new, delay: req_data.delay_seconds,
                                     tag: req_data.alarm_tag};
                        count_in = count_ff + 1'b1;
                     end else begin
                        // start the walk at the tail
                        idx_in  = AW'(count_ff - 1'b1);
                        rd_addr = ring_addr(head_ff, AW'(count_ff - 1'b1));
                     end
                  end
               end else begin
                  now_in        = now_ff + 32'd1;
                  fired_in      = '0;
                  pend_valid_in = 1'b0;
               end
            end
         end
         satq_pkg::S_INS_CHECK: begin
            wr_en   = 1'b1;
            wr_addr = ring_addr(head_ff, idx_ff + 1'b1);
            if (ins_move) begin
               // entry expires at or after the new one: move it up
               wr_data = rd_data;
               if (idx_ff != '0) begin
                  idx_in  = idx_ff - 1'b1;
                  rd_addr = ring_addr(head_ff, idx_ff - 1'b1);
               end
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         satq_pkg::S_INS_PUT: begin
            // new alarm becomes the head
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
         end
         satq_pkg::S_RESULT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_load_data = '{kind: kind_ff, fired_delay: 16'd0,
                                 fired_tag: tag_ff, last: 1'b1};
            end
         end
         satq_pkg::S_FIRE_CHECK: begin
            if (fire_go) begin
               // pop the head; release the previous pending alarm
               head_in       = ring_addr(head_ff, AW'(1));
               rd_addr       = head_in;
               count_in      = count_ff - 1'b1;
               fired_in      = fired_ff + 1'b1;
               pend_valid_in = 1'b1;
               pend_dly_in   = rd_data.delay;
               pend_tag_in   = rd_data.tag;
               if (pend_valid_ff) begin
                  rsp_load      = 1'b1;
                  rsp_load_data = '{kind: satq_pkg::KIND_FIRED, fired_delay: pend_dly_ff,
                                    fired_tag: pend_tag_ff, last: 1'b0};
               end
            end
         end
         satq_pkg::S_FIRE_LAST: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               pend_valid_in = 1'b0;
               rsp_load_data = '{kind: satq_pkg::KIND_FIRED, fired_delay: pend_dly_ff,
                                 fired_tag: pend_tag_ff, last: 1'b1};
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= satq_pkg::S_IDLE;
         now_ff        <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         fired_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         fired_ff      <= fired_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      exp_ff      <= exp_in;
      dly_ff      <= dly_in;
      tag_ff      <= tag_in;
      kind_ff     <= kind_in;
      pend_dly_ff <= pend_dly_in;
      pend_tag_ff <= pend_tag_in;
   end

   // queue never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond queue depth");

   // a tick advances time by exactly one second
   a_tick_time: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op == satq_pkg::OP_TICK) |=> now_ff == $past(now_ff) + 32'd1)
      else $error("tick did not advance time by one");

   // rejection only ever reported for a full queue
   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == satq_pkg::S_RESULT && kind_ff == satq_pkg::KIND_REJECTED)
      |-> is_full)
      else $error("insert rejected with room left");

   // firing never writes the entry store
   a_fire_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == satq_pkg::S_FIRE_CHECK || state_ff == satq_pkg::S_FIRE_LAST)
      |-> !wr_en)
      else $error("RAM written while firing");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted alarm timer queue. A scoreboard keeps
// its own copy of the alarm list and second counter. It predicts every
// accept, reject and fired alarm from the accepted requests and compares
// each response, field by field, in order. The stimulus is a short directed
// pass over the corner cases, then random phases with varied idling,
// one long response hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import satq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // idle limits used by the two drivers, changed per phase
   int send_gap_max;
   int take_gap_max;
   bit hold_request;

   // -------------------------------------------------------------------------
   // scoreboard: alarm list predictor plus queue of owed responses
   // -------------------------------------------------------------------------
   class alarm_queue_scoreboard;
      logic [31:0] now_sec;
      entry_type   slots[QUEUE_DEPTH];
      int          fill;
      rsp_type     owed_results[$];
      int          errors;
      int          checked;

      function new();
         now_sec = '0;
         fill    = 0;
         errors  = 0;
         checked = 0;
      endfunction

      function void report(string msg);
         errors++;
         $display("[%0t] mismatch on response %0d: %s", $realtime, checked, msg);
      endfunction

      // update the alarm list for one accepted request, queue its responses
      function void note_request(req_type r);
         logic [31:0] expiry_at;
         int          pos;
         int          fired;
         rsp_type     res;
         if (r.op == OP_INSERT) begin
            if (fill >= QUEUE_DEPTH) begin
               res = '{KIND_REJECTED, 16'd0, r.alarm_tag, 1'b1};
            end else begin
               expiry_at = now_sec + 32'(r.delay_seconds);
               // new alarm goes ahead of equal expiries
               pos = 0;
               while (pos < fill && slots[pos].expiry < expiry_at)
                  pos++;
               for (int i = fill; i > pos; i--)
                  slots[i] = slots[i-1];
               slots[pos] = '{expiry_at, r.delay_seconds, r.alarm_tag};
               fill++;
               res = '{KIND_ACCEPTED, 16'd0, r.alarm_tag, 1'b1};
            end
            owed_results.push_back(res);
         end else begin
            now_sec = now_sec + 32'd1;
            fired = 0;
            while (fired < fill && fired < MAX_FIRE && slots[fired].expiry <= now_sec)
               fired++;
            for (int i = 0; i < fired; i++) begin
               res = '{KIND_FIRED, slots[i].delay, slots[i].tag, (i == fired - 1)};
               owed_results.push_back(res);
            end
            // pop the fired alarms off the head
            for (int i = fired; i < fill; i++)
               slots[i-fired] = slots[i];
            fill -= fired;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (owed_results.size() == 0) begin
            report($sformatf("unexpected kind %0d delay %h tag %h last %0d",
                             got.kind, got.fired_delay, got.fired_tag, got.last));
            checked++;
            return;
         end
         want = owed_results.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind got %0d want %0d", got.kind, want.kind));
         if (got.fired_delay !== want.fired_delay)
            report($sformatf("fired_delay got %h want %h", got.fired_delay,
                             want.fired_delay));
         if (got.fired_tag !== want.fired_tag)
            report($sformatf("fired_tag got %h want %h", got.fired_tag, want.fired_tag));
         if (got.last !== want.last)
            report($sformatf("last got %0d want %0d", got.last, want.last));
         checked++;
      endfunction
   endclass

   alarm_queue_scoreboard board;

   sorted_alarm_timer_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // transaction monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_request(req_data);
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp_data);
      end
   end

   // response side: random stall before each transaction, one long hold-off
   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            n = $urandom_range(take_gap_max);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!(rsp_valid && !rsp_stall));
            @(negedge clock);
         end
      end
   end

   // offer one request after a random gap; called and returns at a falling edge
   task automatic send_item(input req_type item);
      int gap;
      gap = $urandom_range(send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic send_insert(input logic [15:0] delay, input logic [15:0] tag);
      req_type item;
      item = '{OP_INSERT, delay, tag};
      send_item(item);
   endtask

   // tick with junk in the unused fields
   task automatic send_tick();
      req_type item;
      item = '{OP_TICK, 16'($urandom), 16'($urandom)};
      send_item(item);
   endtask

   // hold the request side until every owed response is in
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.owed_results.size() != 0);
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [15:0] delay;
      board        = new();
      send_gap_max = 19;
      take_gap_max = 19;
      hold_request = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: tick with nothing queued
      send_tick();
      // zero delay fires on the next tick; maximum delay stays queued
      send_insert(16'd0, 16'hFFFF);
      send_insert(16'hFFFF, 16'h0000);
      send_tick();
      // equal expiries: the later insert fires first
      send_insert(16'd2, 16'hA5A5);
      send_insert(16'd2, 16'h5A5A);
      send_tick();
      send_tick();
      // fill the queue, one rejected, then a tick releasing many at once
      for (int i = 0; i < QUEUE_DEPTH - 1; i++)
         send_insert(16'd1, 16'($urandom));
      send_insert(16'd1, 16'h1234);
      send_tick();
      drain_responses();

      // random phases
      for (int p = 0; p < PHASES; p++) begin
         case (p % 5)
            0: begin send_gap_max = 19; take_gap_max = 19; end
            1: begin send_gap_max = 0;  take_gap_max = 0;  end
            2: begin send_gap_max = 0;  take_gap_max = 19; end
            3: begin send_gap_max = 19; take_gap_max = 0;  end
            default: begin send_gap_max = 19; take_gap_max = 19; end
         endcase
         if (p == 3)
            hold_request = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // odd phases lean on inserts to fill the queue, even ones drain it
            if ($urandom_range(99) < ((p % 2 == 1) ? 75 : 40)) begin
               if ($urandom_range(99) < 80)
                  delay = 16'($urandom_range(6));
               else
                  delay = 16'($urandom_range(60));
               send_insert(delay, 16'($urandom));
            end else begin
               send_tick();
            end
         end
         if (p == 5)
            drain_responses();
      end

      // wind down
      req_valid <= 1'b0;
      while (board.owed_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
